// ----- rtl/mte_pkg.sv -----
// Shared types and constants of the multi-tap echo block.
// Used by mte_ctrl, mte_datapath and multi_tap_echo; depends on nothing.
`default_nettype none

package mte_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int MAX_CHANNELS     = 2;
  localparam int MAX_DELAY_FRAMES = 4096;
  localparam int MAX_BOUNCES      = 8;

  localparam int DELAY_W   = 13;
  localparam int CHAN_W    = 2;
  localparam int GAIN_W    = 16;
  localparam int BOUNCE_W  = 4;
  localparam int CFG_DW    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_W    = 15;
  localparam int HIST_AW   = 16;
  localparam int DIST_W    = HIST_AW + 1;
  localparam int SPACING_W = DELAY_W + CHAN_W;
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int ACC_W     = SAMPLE_W + FRAC_W + 5;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_FRAMES  = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2,
    CFG_BOUNCE_COUNT  = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } mte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } mte_sts_t;

endpackage

`default_nettype wire

// ----- rtl/mte_ctrl.sv -----
// Controller of the multi-tap echo: sequences load, tap issue, drain and finish.
// Depends on mte_pkg.
`default_nettype none

module mte_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [mte_pkg::BOUNCE_W-1:0]    bounce_count_i,
  input  wire mte_pkg::mte_sts_t               sts_i,
  output mte_pkg::mte_cmd_t                    cmd_o
);
  import mte_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [BOUNCE_W-1:0] cnt_q;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.issue   = (state_q == ST_ISSUE);
  assign cmd_o.finish  = (state_q == ST_DONE) && sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_ISSUE;
            cnt_q   <= BOUNCE_W'(1);
          end
        end
        ST_ISSUE: begin
          if (cnt_q == bounce_count_i) begin
            state_q <= ST_DRAIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + BOUNCE_W'(1);
          end
        end
        // The drain state lets the last tap pass the read and multiply stages.
        ST_DRAIN: begin
          if (cnt_q == BOUNCE_W'(1)) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + BOUNCE_W'(1);
          end
        end
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mte_datapath.sv -----
// Datapath of the multi-tap echo: history memory, gain powers, tap pipeline,
// accumulator, rounding, saturation and output register. Depends on mte_pkg.
`default_nettype none

module mte_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mte_pkg::mte_cmd_t                cmd_i,
  output mte_pkg::mte_sts_t                     sts_o,
  input  wire logic signed [mte_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                             start_req_i,
  input  wire logic [mte_pkg::DELAY_W-1:0]      delay_frames_i,
  input  wire logic [mte_pkg::CHAN_W-1:0]       channel_count_i,
  input  wire logic [mte_pkg::GAIN_W-1:0]       feedback_gain_i,
  output logic signed [mte_pkg::SAMPLE_W-1:0]   sample_out_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i
);
  import mte_pkg::*;

  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int YW_W       = ACC_W - FRAC_W;

  logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

  logic [SPACING_W-1:0]       spacing;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [HIST_AW-1:0]         wp_q;
  logic [DIST_W-1:0]          seen_q;
  logic [DIST_W-1:0]          dist_q;
  logic [GAIN_W-1:0]          gain_q;
  logic [2*GAIN_W-1:0]        gain_prod;
  logic [HIST_AW-1:0]         rd_addr;
  logic                       tap_ok;

  logic [SAMPLE_W-1:0]        rd_q;
  logic [GAIN_W-1:0]          g1_q;
  logic                       v1_q;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       v2_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic signed [ACC_W-1:0]    rnd;
  logic signed [YW_W-1:0]     yw;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_valid_q;

  assign spacing   = SPACING_W'(delay_frames_i) * SPACING_W'(channel_count_i);
  assign gain_prod = gain_q * feedback_gain_i;
  // The tap index wraps on the ring; a full-depth tap lands on the slot
  // about to be overwritten, which still holds the old sample.
  assign rd_addr   = wp_q - dist_q[HIST_AW-1:0];
  assign tap_ok    = (dist_q <= seen_q);

  assign prod_d = $signed(rd_q) * $signed({1'b0, g1_q});

  // Round half up in Q.15, then clip to the sample range.
  assign rnd = acc_q + ACC_W'(1 << (FRAC_W - 1));
  assign yw  = rnd[ACC_W-1:FRAC_W];

  always_comb begin
    if (yw[YW_W-1:SAMPLE_W-1] == {(YW_W - SAMPLE_W + 1){yw[SAMPLE_W-1]}}) begin
      y_sat = yw[SAMPLE_W-1:0];
    end else if (yw[YW_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sample_out_o   = out_q;
  assign out_valid_o    = out_valid_q;

  // History memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[rd_addr];
    if (cmd_i.finish) begin
      hist_mem[wp_q] <= x_q;
    end
  end

  // Payload registers of the tap pipeline.
  always_ff @(posedge clk_i) begin
    g1_q   <= gain_q;
    prod_q <= prod_d;
    if (cmd_i.load) begin
      x_q    <= sample_in_i;
      dist_q <= DIST_W'(spacing);
      gain_q <= feedback_gain_i;
    end else if (cmd_i.issue) begin
      dist_q <= dist_q + DIST_W'(spacing);
      gain_q <= gain_prod[2*GAIN_W-2:GAIN_W-1];
    end
    if (cmd_i.load) begin
      acc_q <= {{(ACC_W-SAMPLE_W-FRAC_W){sample_in_i[SAMPLE_W-1]}}, sample_in_i,
                {FRAC_W{1'b0}}};
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (cmd_i.finish) begin
      out_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      seen_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue && tap_ok;
      v2_q <= v1_q;
      if (cmd_i.load && start_req_i) begin
        wp_q   <= '0;
        seen_q <= '0;
      end else if (cmd_i.finish) begin
        wp_q <= wp_q + HIST_AW'(1);
        if (seen_q < DIST_W'(HIST_DEPTH)) begin
          seen_q <= seen_q + DIST_W'(1);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_tap_echo.sv -----
// Multi-tap echo: one output sample per input sample, up to eight weighted taps.
// A new input sample is taken only once the current one has been finished; the single
// read port of the history memory serves one tap per cycle.
// Reset clears control state and loads register defaults; history is not
// cleared, since taps never reach past the samples seen in the current buffer.
`default_nettype none

module multi_tap_echo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mte_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                                start_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [mte_pkg::SAMPLE_W-1:0]      sample_out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [mte_pkg::CFG_DW-1:0]          cfg_data_i
);
  import mte_pkg::*;

  logic [DELAY_W-1:0]  delay_frames_q;
  logic [CHAN_W-1:0]   channel_count_q;
  logic [GAIN_W-1:0]   feedback_gain_q;
  logic [BOUNCE_W-1:0] bounce_count_q;

  logic [DELAY_W-1:0]  delay_wr;
  logic [CHAN_W-1:0]   chan_wr;
  logic [GAIN_W-1:0]   gain_wr;
  logic [BOUNCE_W-1:0] bounce_wr;
  logic [DELAY_W-1:0]  delay_d;
  logic [CHAN_W-1:0]   chan_d;
  logic [GAIN_W-1:0]   gain_d;
  logic [BOUNCE_W-1:0] bounce_d;

  mte_cmd_t cmd;
  mte_sts_t sts;

  assign delay_wr  = cfg_data_i[DELAY_W-1:0];
  assign chan_wr   = cfg_data_i[CHAN_W-1:0];
  assign gain_wr   = cfg_data_i[GAIN_W-1:0];
  assign bounce_wr = cfg_data_i[BOUNCE_W-1:0];

  // Written values are clamped into their legal ranges.
  always_comb begin
    if (delay_wr == '0) begin
      delay_d = DELAY_W'(1);
    end else if (delay_wr > DELAY_W'(MAX_DELAY_FRAMES)) begin
      delay_d = DELAY_W'(MAX_DELAY_FRAMES);
    end else begin
      delay_d = delay_wr;
    end
    if (chan_wr == '0) begin
      chan_d = CHAN_W'(1);
    end else if (chan_wr > CHAN_W'(MAX_CHANNELS)) begin
      chan_d = CHAN_W'(MAX_CHANNELS);
    end else begin
      chan_d = chan_wr;
    end
    if (gain_wr > GAIN_ONE) begin
      gain_d = GAIN_ONE;
    end else begin
      gain_d = gain_wr;
    end
    if (bounce_wr == '0) begin
      bounce_d = BOUNCE_W'(1);
    end else if (bounce_wr > BOUNCE_W'(MAX_BOUNCES)) begin
      bounce_d = BOUNCE_W'(MAX_BOUNCES);
    end else begin
      bounce_d = bounce_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_frames_q  <= DELAY_W'(1);
      channel_count_q <= CHAN_W'(1);
      feedback_gain_q <= '0;
      bounce_count_q  <= BOUNCE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DELAY_FRAMES:  delay_frames_q  <= delay_d;
        CFG_CHANNEL_COUNT: channel_count_q <= chan_d;
        CFG_FEEDBACK_GAIN: feedback_gain_q <= gain_d;
        CFG_BOUNCE_COUNT:  bounce_count_q  <= bounce_d;
        default: ;
      endcase
    end
  end

  mte_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .bounce_count_i (bounce_count_q),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  mte_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_in_i     (sample_in_i),
    .start_req_i     (start_req_i),
    .delay_frames_i  (delay_frames_q),
    .channel_count_i (channel_count_q),
    .feedback_gain_i (feedback_gain_q),
    .sample_out_o    (sample_out_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule

`default_nettype wire
